/* hdl/lhtn_pkg.sv */
// Shared types and constants for the latency log2 histogram with top-N list.
package lhtn_pkg;

	localparam int CNT_W     = 64;    // histogram counter width
	localparam int NS_W      = 64;    // elapsed time width
	localparam int DLT_W     = 55;    // microsecond delta width
	localparam int STK_W     = 32;    // stack id width
	localparam int IDX_W     = 6;     // read index, bucket and rank width
	localparam int NS_PER_US = 1000;

	localparam logic [STK_W-1:0] NO_STACK = '1;

	localparam logic [1:0] OP_RECORD = 2'd0;
	localparam logic [1:0] OP_RD_BKT = 2'd1;
	localparam logic [1:0] OP_RD_TOP = 2'd2;

	// divider result, valid for the cycle that done is high
	typedef struct packed {
		logic             done;
		logic [DLT_W-1:0] quot;
		logic [IDX_W-1:0] lg;
	} div_res_t;

endpackage

/* hdl/lhtn_div.sv */
// Ns-to-us divide by 1000 as a reciprocal multiply on one 32x32 multiplier, with floor log2.
module lhtn_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [lhtn_pkg::NS_W-1:0]    dividend,
	output lhtn_pkg::div_res_t           res
);

	// ns / 1000 == (ns >> 3) / 125 == ((ns >> 3) * RECIP) >> 68 for every 61-bit value,
	// since the reciprocal error (19) times 2^61 stays below 2^68
	localparam int          YW    = lhtn_pkg::NS_W - 3;
	localparam int          QSH   = 68;
	localparam int          ACC_W = 128;
	localparam logic [63:0] RECIP = 64'd2361183241434822607;   // ceil(2^68 / 125)

	logic [YW-1:0]              y_q;
	logic [2:0]                 step_q;
	logic                       run_q;
	logic                       done_q;
	logic [31:0]                mul_a;
	logic [31:0]                mul_b;
	logic [63:0]                prod_q;
	logic [ACC_W-1:0]           acc_q;
	logic [ACC_W-1:0]           addend;
	logic [lhtn_pkg::DLT_W-1:0] quot;
	logic [lhtn_pkg::IDX_W-1:0] lg;

	// partial products lo*lo, lo*hi, hi*lo, hi*hi, one per step
	assign mul_a = step_q[1] ? 32'(y_q[YW-1:32]) : y_q[31:0];
	assign mul_b = step_q[0] ? RECIP[63:32] : RECIP[31:0];

	// the product registered in the previous step, placed at its weight
	always_comb begin
		unique case (step_q)
			3'd2, 3'd3: addend = {32'd0, prod_q, 32'd0};
			3'd4:       addend = {prod_q, 64'd0};
			default:    addend = {64'd0, prod_q};
		endcase
	end

	assign quot = acc_q[QSH +: lhtn_pkg::DLT_W];

	// floor log2, zero maps to zero
	always_comb begin
		lg = '0;
		for (int i = 0; i < lhtn_pkg::DLT_W; i++) begin
			if (quot[i]) begin
				lg = lhtn_pkg::IDX_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + 3'd1;
				if (step_q == 3'd4) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			y_q   <= dividend[lhtn_pkg::NS_W-1:3];
			acc_q <= '0;
		end else if (run_q) begin
			prod_q <= {32'd0, mul_a} * {32'd0, mul_b};
			if (step_q != 3'd0) begin
				acc_q <= acc_q + addend;
			end
		end
	end

	assign res.done = done_q;
	assign res.quot = quot;
	assign res.lg   = lg;

endmodule

/* hdl/lhtn_hist.sv */
// Histogram counter memory: synchronous read with registered data, per-entry valid bits for reset.
module lhtn_hist #(
	parameter int BUCKETS = 32,
	parameter int BIW     = 5
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rd_en,
	input  logic [BIW-1:0]               rd_addr,
	output logic [lhtn_pkg::CNT_W-1:0]   rd_data,
	input  logic                         wr_en,
	input  logic [BIW-1:0]               wr_addr,
	input  logic [lhtn_pkg::CNT_W-1:0]   wr_data
);

	logic [lhtn_pkg::CNT_W-1:0] mem [BUCKETS];
	logic [BUCKETS-1:0]         vld_q;
	logic [lhtn_pkg::CNT_W-1:0] rdat_s1;
	logic                       rvld_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdat_s1 <= mem[rd_addr];
		end
	end

	// an entry never written since reset reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			rvld_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			rvld_s1 <= rd_en && vld_q[rd_addr];
		end
	end

	assign rd_data = rvld_s1 ? rdat_s1 : '0;

endmodule

/* hdl/lhtn_top.sv */
// Descending top-N list of (delta, stack) with parallel compare-and-shift insert.
module lhtn_top #(
	parameter int TOP_N = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         ins_en,
	input  logic [lhtn_pkg::DLT_W-1:0]   ins_delta,
	input  logic [lhtn_pkg::STK_W-1:0]   ins_stack,
	output logic [lhtn_pkg::IDX_W-1:0]   ins_rank,
	input  logic [lhtn_pkg::IDX_W-1:0]   rd_idx,
	output logic [lhtn_pkg::DLT_W-1:0]   rd_delta,
	output logic [lhtn_pkg::STK_W-1:0]   rd_stack
);

	logic [lhtn_pkg::DLT_W-1:0] dlt_q [TOP_N];
	logic [lhtn_pkg::STK_W-1:0] stk_q [TOP_N];
	logic [TOP_N-1:0]           ge;

	// list stays sorted, so ge is a run of ones from the first hit to the end
	always_comb begin
		for (int i = 0; i < TOP_N; i++) begin
			ge[i] = (ins_delta >= dlt_q[i]);
		end
	end

	always_comb begin
		ins_rank = lhtn_pkg::IDX_W'(TOP_N);
		for (int i = TOP_N - 1; i >= 0; i--) begin
			if (ge[i]) begin
				ins_rank = lhtn_pkg::IDX_W'(i);
			end
		end
	end

	always_comb begin
		rd_delta = '0;
		rd_stack = '0;
		for (int i = 0; i < TOP_N; i++) begin
			if (rd_idx == lhtn_pkg::IDX_W'(i)) begin
				rd_delta = dlt_q[i];
				rd_stack = stk_q[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TOP_N; i++) begin
				dlt_q[i] <= '0;
				stk_q[i] <= '0;
			end
		end else if (ins_en) begin
			for (int i = 0; i < TOP_N; i++) begin
				if (ge[i]) begin
					if (i == 0) begin
						dlt_q[i] <= ins_delta;
						stk_q[i] <= ins_stack;
					end else if (!ge[(i > 0) ? i - 1 : 0]) begin
						dlt_q[i] <= ins_delta;
						stk_q[i] <= ins_stack;
					end else begin
						dlt_q[i] <= dlt_q[(i > 0) ? i - 1 : 0];
						stk_q[i] <= stk_q[(i > 0) ? i - 1 : 0];
					end
				end
			end
		end
	end

endmodule

/* hdl/latency_log2_histogram_top_n.sv */
// Top level: command FSM tying the divider, histogram memory and top-N list together.
// Record: the 5-step ns-to-us reciprocal multiply (one 32x32 product a step) runs first,
//   then the list insert with the bucket read, the counter write-back and the result strobe.
// Read bucket: one memory read. Read top entry and unused opcode: no memory read.
// One command at a time; the receiver cannot stall; a new command is taken at the edge
//   that ends the strobe cycle.
// Async reset clears the FSM, stack_enable, the top list and all bucket valid bits.
module latency_log2_histogram_top_n #(
	parameter int BUCKETS = 32,
	parameter int TOP_N   = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// command transaction
	input  logic                                 start,
	output logic                                 busy,
	input  logic [1:0]                           opcode,
	input  logic [lhtn_pkg::NS_W-1:0]            elapsed_ns,
	input  logic [lhtn_pkg::STK_W-1:0]           stack_id,
	input  logic [lhtn_pkg::IDX_W-1:0]           read_index,
	// configuration
	input  logic                                 cfg_we,
	input  logic                                 cfg_wdata,
	// result transaction
	output logic                                 done,
	output logic [lhtn_pkg::IDX_W-1:0]           bucket,
	output logic [lhtn_pkg::CNT_W-1:0]           count,
	output logic [lhtn_pkg::IDX_W-1:0]           rank,
	output logic [lhtn_pkg::DLT_W-1:0]           entry_delta_us,
	output logic [lhtn_pkg::STK_W-1:0]           entry_stack
);

	localparam int BIW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,    // divider running
		ST_READ,   // read and unused opcodes: issue memory read, or answer from the list or with zeros
		ST_HDATA   // memory data back: update counter on a record, send result
	} state_t;

	state_t                         state_q;
	logic [1:0]                     op_q;
	logic [lhtn_pkg::IDX_W-1:0]     idx_q;
	logic [lhtn_pkg::STK_W-1:0]     sid_q;
	logic                           stack_en_q;
	logic                           done_q;
	logic [lhtn_pkg::IDX_W-1:0]     bucket_q;
	logic [lhtn_pkg::CNT_W-1:0]     count_q;
	logic [lhtn_pkg::IDX_W-1:0]     rank_q;
	logic [lhtn_pkg::DLT_W-1:0]     delta_q;
	logic [lhtn_pkg::STK_W-1:0]     stack_q;

	logic                           accept;
	logic                           div_start;
	lhtn_pkg::div_res_t             div_res;
	logic [lhtn_pkg::IDX_W-1:0]     bkt_clamp;
	logic                           idx_in_bkt;
	logic                           ins_en;
	logic [lhtn_pkg::IDX_W-1:0]     top_rank;
	logic [lhtn_pkg::DLT_W-1:0]     top_delta;
	logic [lhtn_pkg::STK_W-1:0]     top_stack;
	logic                           hist_re;
	logic [BIW-1:0]                 hist_raddr;
	logic [lhtn_pkg::CNT_W-1:0]     hist_rdata;
	logic                           hist_we;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign div_start = accept && (opcode == lhtn_pkg::OP_RECORD);

	// floor log2 clamped to the last bucket
	assign bkt_clamp = ({1'b0, div_res.lg} >= (lhtn_pkg::IDX_W + 1)'(BUCKETS)) ?
		lhtn_pkg::IDX_W'(BUCKETS - 1) : div_res.lg;
	assign idx_in_bkt = ({1'b0, idx_q} < (lhtn_pkg::IDX_W + 1)'(BUCKETS));

	// list insert and bucket read both fire on the divider's done cycle
	assign ins_en     = (state_q == ST_DIV) && div_res.done;
	assign hist_re    = ins_en ||
		((state_q == ST_READ) && (op_q == lhtn_pkg::OP_RD_BKT) && idx_in_bkt);
	assign hist_raddr = (state_q == ST_DIV) ? bkt_clamp[BIW-1:0] : idx_q[BIW-1:0];
	// write-back in the cycle after the read; FSM keeps the next read later
	assign hist_we    = (state_q == ST_HDATA) && (op_q == lhtn_pkg::OP_RECORD);

	lhtn_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (elapsed_ns),
		.res      (div_res)
	);

	lhtn_hist #(
		.BUCKETS (BUCKETS),
		.BIW     (BIW)
	) u_hist (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (hist_re),
		.rd_addr (hist_raddr),
		.rd_data (hist_rdata),
		.wr_en   (hist_we),
		.wr_addr (bucket_q[BIW-1:0]),
		.wr_data (hist_rdata + 64'd1)
	);

	lhtn_top #(
		.TOP_N (TOP_N)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.ins_en    (ins_en),
		.ins_delta (div_res.quot),
		.ins_stack (sid_q),
		.ins_rank  (top_rank),
		.rd_idx    (idx_q),
		.rd_delta  (top_delta),
		.rd_stack  (top_stack)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stack_en_q <= 1'b0;
		end else if (cfg_we) begin
			stack_en_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			done_q   <= 1'b0;
			op_q     <= lhtn_pkg::OP_RECORD;
			idx_q    <= '0;
			sid_q    <= '0;
			bucket_q <= '0;
			count_q  <= '0;
			rank_q   <= '0;
			delta_q  <= '0;
			stack_q  <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						op_q     <= opcode;
						idx_q    <= read_index;
						sid_q    <= stack_en_q ? stack_id : lhtn_pkg::NO_STACK;
						// fields an opcode leaves alone go out as zero
						bucket_q <= '0;
						count_q  <= '0;
						rank_q   <= '0;
						delta_q  <= '0;
						stack_q  <= '0;
						state_q  <= (opcode == lhtn_pkg::OP_RECORD) ? ST_DIV : ST_READ;
					end
				end
				ST_DIV: begin
					if (div_res.done) begin
						bucket_q <= bkt_clamp;
						rank_q   <= top_rank;
						state_q  <= ST_HDATA;
					end
				end
				ST_READ: begin
					if (op_q == lhtn_pkg::OP_RD_BKT) begin
						state_q <= ST_HDATA;
					end else begin
						if (op_q == lhtn_pkg::OP_RD_TOP) begin
							delta_q <= top_delta;
							stack_q <= top_stack;
						end
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_HDATA: begin
					count_q <= hist_rdata;
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done           = done_q;
	assign bucket         = bucket_q;
	assign count          = count_q;
	assign rank           = rank_q;
	assign entry_delta_us = delta_q;
	assign entry_stack    = stack_q;

	// a result only follows a command that was in flight
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_READ || state_q == ST_HDATA))
		else $error("result strobe without a command in flight");

	// the divider only finishes while the FSM waits for it
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |-> (state_q == ST_DIV))
		else $error("divider finished outside the divide state");

	// counter write-back always follows a read of the same record
	a_we_after_re: assert property (@(posedge clk) disable iff (!arst_n)
		hist_we |-> $past(hist_re))
		else $error("histogram write without preceding read");

	// a recorded rank never exceeds the list length
	a_rank_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rank <= lhtn_pkg::IDX_W'(TOP_N)))
		else $error("rank beyond the top list");

endmodule
